@@ sv/svd_pkg.sv @@
// Shared types, constants and the arctangent table for the 2x2 SVD block.
package svd_pkg;

	// defaults for top-level parameters
	localparam int CORDIC_STAGES = 16;

	// binary angle units: pi = 2^30
	localparam int ZW = 33;
	localparam logic signed [ZW-1:0] ANG_PI      = 33'sd1073741824;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 33'sd536870912;

	// CORDIC gain compensation, Q.30
	localparam logic signed [31:0] INV_GAIN = 32'sd652032874;

	// vectoring datapath width (guarded E/F/G/H plus growth)
	localparam int VW = 28;
	// rotation datapath width
	localparam int RW = 32;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [RW-1:0] x;
		logic signed [RW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
	} rot_t;

	// atan(2^-i) in binary angle units
	function automatic logic [31:0] atan_at(input int i);
		logic [31:0] v;
		case (i)
			0:  v = 32'd268435456;
			1:  v = 32'd158466703;
			2:  v = 32'd83729454;
			3:  v = 32'd42502378;
			4:  v = 32'd21333666;
			5:  v = 32'd10677233;
			6:  v = 32'd5339919;
			7:  v = 32'd2670123;
			8:  v = 32'd1335082;
			9:  v = 32'd667543;
			10: v = 32'd333772;
			11: v = 32'd166886;
			12: v = 32'd83443;
			13: v = 32'd41722;
			14: v = 32'd20861;
			15: v = 32'd10430;
			16: v = 32'd5215;
			17: v = 32'd2608;
			18: v = 32'd1304;
			19: v = 32'd652;
			20: v = 32'd326;
			21: v = 32'd163;
			22: v = 32'd81;
			23: v = 32'd41;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/signed_svd_2x2.sv @@
// Top level: pipelined closed-form signed SVD of a 2x2 Q3.12 matrix.
//
// Input stream s_axis_*: one matrix per transfer, tdata = {a11,a10,a01,a00},
// a00 in the lowest 16 bits. Output stream m_axis_*: one result per matrix,
// fields packed from bit 0: sigma_one, sigma_two, u_cos, u_sin, v_cos,
// v_sin, rot_cos, rot_sin, asap_scale, then three zero pad bits.
// Throughput: one matrix per cycle, sustained while the receiver does not stall,
// with no bubbles between items. Pipeline: 2*CORDIC_STAGES + 5 register stages
// (setup, vectoring cells, gain multiply, angle forming, fold, rotation cells,
// output register); the setup stage loads at the input transfer edge. The two
// rows of vectoring cells and the three rows of rotation cells each advance one
// iteration per cycle while the pipeline is not stalled.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
// only while a result waits in the output register; nothing is lost.
// Reset clears all valid flags; the block then takes a matrix at once.
module signed_svd_2x2 #(
	parameter int CORDIC_STAGES = svd_pkg::CORDIC_STAGES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // a00, a01, a10, a11
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [151:0] m_axis_tdata   // sigma_one, sigma_two, u_cos, u_sin,
	                                    // v_cos, v_sin, rot_cos, rot_sin, asap_scale
);

	localparam int N = CORDIC_STAGES;
	localparam int VW = svd_pkg::VW;
	localparam int ZW = svd_pkg::ZW;
	localparam int RW = svd_pkg::RW;
	localparam int PW = VW + 32;

	logic ce;
	assign ce = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	// input setup: sums/differences with guard bits, left-half fold
	logic signed [15:0] a00, a01, a10, a11;
	logic signed [16:0] se, sf, sg, sh;
	svd_pkg::vec_t ve_in, vf_in;
	logic ze_in, zf_in;

	function automatic svd_pkg::vec_t vinit(input logic signed [16:0] xs,
	                                         input logic signed [16:0] ys);
		svd_pkg::vec_t v;
		logic signed [VW-1:0] x, y;
		x = VW'($signed({xs, 8'b0}));
		y = VW'($signed({ys, 8'b0}));
		v.z = '0;
		v.x = x;
		v.y = y;
		if (x[VW-1]) begin
			v.z = y[VW-1] ? -svd_pkg::ANG_PI : svd_pkg::ANG_PI;
			v.x = -x;
			v.y = -y;
		end
		return v;
	endfunction

	always_comb begin
		a00 = s_axis_tdata[15:0];
		a01 = s_axis_tdata[31:16];
		a10 = s_axis_tdata[47:32];
		a11 = s_axis_tdata[63:48];
		se = 17'(a00) + 17'(a11);
		sf = 17'(a00) - 17'(a11);
		sg = 17'(a10) + 17'(a01);
		sh = 17'(a10) - 17'(a01);
		ve_in = vinit(se, sh);
		vf_in = vinit(sf, sg);
		ze_in = (se == '0) && (sh == '0);
		zf_in = (sf == '0) && (sg == '0);
	end

	svd_pkg::vec_t ve [0:N];
	svd_pkg::vec_t vf [0:N];
	logic vld_v [0:N];
	logic ze_v [0:N];
	logic zf_v [0:N];
	svd_pkg::vec_t ve_s1, vf_s1;
	logic vld_s1, ze_s1, zf_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ve_s1 <= ve_in;
			vf_s1 <= vf_in;
			ze_s1 <= ze_in;
			zf_s1 <= zf_in;
		end
	end

	assign ve[0] = ve_s1;
	assign vf[0] = vf_s1;
	assign vld_v[0] = vld_s1;
	assign ze_v[0] = ze_s1;
	assign zf_v[0] = zf_s1;

	// vectoring cell rows and their sideband flags
	for (genvar i = 0; i < N; i++) begin : g_vec
		logic vld_q, ze_q, zf_q;
		svd_vcell #(.IDX(i)) u_ce (.clk(clk), .ce(ce), .d(ve[i]), .dout(ve[i+1]));
		svd_vcell #(.IDX(i)) u_cf (.clk(clk), .ce(ce), .d(vf[i]), .dout(vf[i+1]));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
			end else if (ce) begin
				vld_q <= vld_v[i];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				ze_q <= ze_v[i];
				zf_q <= zf_v[i];
			end
		end
		assign vld_v[i+1] = vld_q;
		assign ze_v[i+1] = ze_q;
		assign zf_v[i+1] = zf_q;
	end

	// gain compensation multiply; zero vector gives angle 0
	logic signed [PW-1:0] pe_s2, pf_s2;
	logic signed [ZW-1:0] t2_s2, t1_s2;
	logic vld_s2;

	always_ff @(posedge clk) begin
		if (ce) begin
			pe_s2 <= PW'(ve[N].x) * PW'(svd_pkg::INV_GAIN);
			pf_s2 <= PW'(vf[N].x) * PW'(svd_pkg::INV_GAIN);
			t2_s2 <= ze_v[N] ? '0 : ve[N].z;
			t1_s2 <= zf_v[N] ? '0 : vf[N].z;
		end
	end

	// magnitudes rounded from Q.30, U and V angles
	localparam int MW = PW - 30;
	logic signed [PW-1:0] pe_r, pf_r;
	logic signed [ZW:0] sum_t, dif_t;
	logic signed [MW-1:0] q_s3, r_s3;
	logic signed [ZW-1:0] phi_s3, th_s3, t2_s3;
	logic vld_s3;

	always_comb begin
		pe_r = pe_s2 + (PW'(1) <<< 29);
		pf_r = pf_s2 + (PW'(1) <<< 29);
		sum_t = (ZW+1)'(t2_s2) + (ZW+1)'(t1_s2);
		dif_t = (ZW+1)'(t2_s2) - (ZW+1)'(t1_s2);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			q_s3 <= pe_r[PW-1:30];
			r_s3 <= pf_r[PW-1:30];
			phi_s3 <= sum_t[ZW:1];
			th_s3 <= dif_t[ZW:1];
			t2_s3 <= t2_s2;
		end
	end

	// singular values, scale and angle folding
	function automatic logic signed [17:0] sat18(input logic signed [MW:0] v);
		logic signed [MW:0] t;
		logic signed [MW-9:0] s;
		t = v + (MW+1)'(256);
		s = t[MW:9];
		if (s > (MW-8)'(131071)) return 18'sd131071;
		else if (s < -(MW-8)'(131072)) return -18'sd131072;
		else return s[17:0];
	endfunction

	function automatic svd_pkg::rot_t rinit(input logic signed [ZW-1:0] a);
		svd_pkg::rot_t r;
		r.x = svd_pkg::INV_GAIN;
		r.y = '0;
		r.z = a;
		r.neg = 1'b0;
		if (a > svd_pkg::ANG_HALF_PI) begin
			r.z = a - svd_pkg::ANG_PI;
			r.neg = 1'b1;
		end else if (a < -svd_pkg::ANG_HALF_PI) begin
			r.z = a + svd_pkg::ANG_PI;
			r.neg = 1'b1;
		end
		return r;
	endfunction

	logic signed [17:0] s1_s4, s2_s4, scs_s4;
	svd_pkg::rot_t ru_s4, rv_s4, rr_s4;
	logic vld_s4;

	always_ff @(posedge clk) begin
		if (ce) begin
			s1_s4 <= sat18((MW+1)'(q_s3) + (MW+1)'(r_s3));
			s2_s4 <= sat18((MW+1)'(q_s3) - (MW+1)'(r_s3));
			scs_s4 <= sat18((MW+1)'(q_s3));
			ru_s4 <= rinit(phi_s3);
			rv_s4 <= rinit(th_s3);
			rr_s4 <= rinit(t2_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ce) begin
			vld_s2 <= vld_v[N];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// rotation cell rows, singular values ride alongside
	svd_pkg::rot_t ru [0:N];
	svd_pkg::rot_t rv [0:N];
	svd_pkg::rot_t rr [0:N];
	logic vld_r [0:N];
	logic signed [17:0] s1_r [0:N];
	logic signed [17:0] s2_r [0:N];
	logic signed [17:0] sc_r [0:N];

	assign ru[0] = ru_s4;
	assign rv[0] = rv_s4;
	assign rr[0] = rr_s4;
	assign vld_r[0] = vld_s4;
	assign s1_r[0] = s1_s4;
	assign s2_r[0] = s2_s4;
	assign sc_r[0] = scs_s4;

	for (genvar i = 0; i < N; i++) begin : g_rot
		logic vld_q;
		logic signed [17:0] s1_q, s2_q, sc_q;
		svd_rcell #(.IDX(i)) u_cu (.clk(clk), .ce(ce), .d(ru[i]), .dout(ru[i+1]));
		svd_rcell #(.IDX(i)) u_cv (.clk(clk), .ce(ce), .d(rv[i]), .dout(rv[i+1]));
		svd_rcell #(.IDX(i)) u_cr (.clk(clk), .ce(ce), .d(rr[i]), .dout(rr[i+1]));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
			end else if (ce) begin
				vld_q <= vld_r[i];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				s1_q <= s1_r[i];
				s2_q <= s2_r[i];
				sc_q <= sc_r[i];
			end
		end
		assign vld_r[i+1] = vld_q;
		assign s1_r[i+1] = s1_q;
		assign s2_r[i+1] = s2_q;
		assign sc_r[i+1] = sc_q;
	end

	// unfold, round to Q1.14 and clamp
	function automatic logic signed [15:0] q14(input logic signed [RW-1:0] v,
	                                           input logic neg);
		logic signed [RW:0] t;
		logic signed [RW-16:0] s;
		t = neg ? -(RW+1)'(v) : (RW+1)'(v);
		t = t + (RW+1)'(32768);
		s = t[RW:16];
		if (s > (RW-15)'(16384)) return 16'sd16384;
		else if (s < -(RW-15)'(16384)) return -16'sd16384;
		else return s[15:0];
	endfunction

	logic [151:0] res;
	always_comb begin
		res = {3'b000,
		       sc_r[N][16:0],
		       q14(rr[N].y, rr[N].neg), q14(rr[N].x, rr[N].neg),
		       q14(rv[N].y, rv[N].neg), q14(rv[N].x, rv[N].neg),
		       q14(ru[N].y, ru[N].neg), q14(ru[N].x, ru[N].neg),
		       s2_r[N], s1_r[N]};
	end

	// output register
	logic out_vld_q;
	logic [151:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ce) begin
			out_vld_q <= vld_r[N];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) out_q <= res;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_q;

endmodule

@@ sv/svd_vcell.sv @@
// One vectoring CORDIC iteration cell, registered.
module svd_vcell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          ce,
	input  svd_pkg::vec_t d,
	output svd_pkg::vec_t dout
);

	svd_pkg::vec_t nxt;
	svd_pkg::vec_t r_q;
	logic signed [svd_pkg::VW-1:0] dx, dy;
	logic signed [svd_pkg::ZW-1:0] at;

	// drive y toward zero
	always_comb begin
		dx = d.y >>> IDX;
		dy = d.x >>> IDX;
		at = $signed({1'b0, svd_pkg::atan_at(IDX)});
		nxt = d;
		if (!d.y[svd_pkg::VW-1]) begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + at;
		end else begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - at;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) r_q <= nxt;
	end

	assign dout = r_q;

endmodule

@@ sv/svd_rcell.sv @@
// One rotation CORDIC iteration cell, registered.
module svd_rcell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          ce,
	input  svd_pkg::rot_t d,
	output svd_pkg::rot_t dout
);

	svd_pkg::rot_t nxt;
	svd_pkg::rot_t r_q;
	logic signed [svd_pkg::RW-1:0] dx, dy;
	logic signed [svd_pkg::ZW-1:0] at;

	// drive z toward zero
	always_comb begin
		dx = d.y >>> IDX;
		dy = d.x >>> IDX;
		at = $signed({1'b0, svd_pkg::atan_at(IDX)});
		nxt = d;
		if (!d.z[svd_pkg::ZW-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - at;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) r_q <= nxt;
	end

	assign dout = r_q;

endmodule

@@ tb/tb_top.sv @@
// Testbench for the 2x2 signed SVD block: stream stimulus with a scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 2*svd_pkg::CORDIC_STAGES + 5;
	localparam int N_STAGES = svd_pkg::CORDIC_STAGES;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint A_PI = 64'sd1073741824;
	localparam longint A_HALF_PI = 64'sd536870912;
	localparam longint GAIN_INV = 64'sd652032874;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;    // a00, a01, a10, a11
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [151:0] m_axis_tdata;        // sigma_one .. asap_scale

	typedef struct packed {
		logic [16:0] asap_scale;
		logic signed [15:0] rot_sin, rot_cos, v_sin, v_cos, u_sin, u_cos;
		logic signed [17:0] sigma_two, sigma_one;
	} svd_res_t;

	svd_res_t expected_q[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;
	int mismatches = 0;
	int n_sent = 0;
	int n_checked = 0;
	int idle_cycles = 0;

	signed_svd_2x2 dut (.*);

	always #6 clk = ~clk;

	// arctangent table, binary angle with pi = 2^30
	function automatic longint atan_step(int i);
		return longint'(svd_pkg::atan_at(i));
	endfunction

	// floor shift
	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_shr(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// magnitude and angle of (x, y)
	function automatic void polar(input longint x0, input longint y0, output longint mag,
			output longint ang);
		longint x, y, z, dx, dy;
		x = x0; y = y0; z = 0;
		if (x == 0 && y == 0) begin
			mag = 0; ang = 0;
			return;
		end
		if (x < 0) begin
			z = (y >= 0) ? A_PI : -A_PI;
			x = -x; y = -y;
		end
		for (int i = 0; i < N_STAGES; i++) begin
			dx = fshr(y, i); dy = fshr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		mag = rnd_shr(x * GAIN_INV, 30);
		ang = z;
	endfunction

	// cosine and sine, Q1.14
	function automatic void cos_sin(input longint a, output logic signed [15:0] c,
			output logic signed [15:0] s);
		longint x, y, z, dx, dy;
		bit flip;
		x = GAIN_INV; y = 0; z = a; flip = 0;
		if (z > A_HALF_PI) begin
			z -= A_PI; flip = 1;
		end else if (z < -A_HALF_PI) begin
			z += A_PI; flip = 1;
		end
		for (int i = 0; i < N_STAGES; i++) begin
			dx = fshr(y, i); dy = fshr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = 16'(sat(rnd_shr(x, 16), -16384, 16384));
		s = 16'(sat(rnd_shr(y, 16), -16384, 16384));
	endfunction

	function automatic svd_res_t predict_svd(logic [63:0] m);
		longint a00, a01, a10, a11, q, r, t1, t2, phi, theta;
		svd_res_t res;
		a00 = longint'($signed(m[15:0]));
		a01 = longint'($signed(m[31:16]));
		a10 = longint'($signed(m[47:32]));
		a11 = longint'($signed(m[63:48]));
		polar((a00 + a11) * 256, (a10 - a01) * 256, q, t2);
		polar((a00 - a11) * 256, (a10 + a01) * 256, r, t1);
		phi = fshr(t2 + t1, 1);
		theta = fshr(t2 - t1, 1);
		res.sigma_one = 18'(sat(rnd_shr(q + r, 9), -131072, 131071));
		res.sigma_two = 18'(sat(rnd_shr(q - r, 9), -131072, 131071));
		res.asap_scale = 17'(sat(rnd_shr(q, 9), 0, 131071));
		cos_sin(phi, res.u_cos, res.u_sin);
		cos_sin(theta, res.v_cos, res.v_sin);
		cos_sin(t2, res.rot_cos, res.rot_sin);
		return res;
	endfunction

	// send one matrix, random gaps before it
	task automatic send_matrix(input logic [15:0] a00, a01, a10, a11);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {a11, a10, a01, a00};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_q.insert(expected_q.size(), predict_svd({a11, a10, a01, a00}));
		n_sent++;
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
	endtask

	// receiver ready
	always @(posedge clk) begin
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			svd_res_t got, want;
			got = svd_res_t'(m_axis_tdata[148:0]);
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_q.pop_front();
				n_checked++;
				if (got !== want || m_axis_tdata[151:149] !== 3'b0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch #%0d: s1 %0d/%0d s2 %0d/%0d sc %0d/%0d",
							n_checked, want.sigma_one, got.sigma_one,
							want.sigma_two, got.sigma_two,
							want.asap_scale, got.asap_scale);
						$display("  u %0d,%0d/%0d,%0d v %0d,%0d/%0d,%0d r %0d,%0d/%0d,%0d",
							want.u_cos, want.u_sin, got.u_cos, got.u_sin,
							want.v_cos, want.v_sin, got.v_cos, got.v_sin,
							want.rot_cos, want.rot_sin, got.rot_cos, got.rot_sin);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] rand_entry();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(16'($signed($urandom_range(8192)) - 16'sd4096));
			3: return 16'h0;
			default: return 16'($urandom);
		endcase
	endfunction

	// extremes and special cases
	task automatic test_directed();
		send_matrix(16'h0000, 16'h0000, 16'h0000, 16'h0000); // zero vectors
		send_matrix(16'h1000, 16'h0000, 16'h0000, 16'h1000); // identity
		send_matrix(16'hF000, 16'h0000, 16'h0000, 16'hF000); // E negative, H zero
		send_matrix(16'h1000, 16'h0000, 16'h0000, 16'hF000); // reflection
		send_matrix(16'h0000, 16'hF000, 16'h1000, 16'h0000); // pure rotation +90
		send_matrix(16'h0000, 16'h1000, 16'hF000, 16'h0000); // pure rotation -90
		send_matrix(16'hF000, 16'h0800, 16'hF800, 16'hF000); // left half plane, y<0
		send_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_matrix(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF); // large sigma
		send_matrix(16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
		send_matrix(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		send_matrix(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_matrix(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
		send_matrix(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
		send_matrix(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
		end_burst();
	endtask

	task automatic test_random(input int count);
		repeat (count) send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry());
		end_burst();
	endtask

	// receiver holds off long while the sender keeps offering
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (3 * LATENCY) @(posedge clk);
				hold_off = 1'b0;
			end
			test_random(4 * LATENCY);
		join
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 33; recv_idle_pct = 63;
		test_directed();
		test_random(160);
		send_idle_pct = 63; recv_idle_pct = 33;
		test_random(160);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_backpressure();
		test_random(80);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("%0d matrices sent, %0d results checked: extremes, zero vectors,",
			n_sent, n_checked);
		$display("saturation, random entries under three idle mixes and a long stall");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
